@@ rtl/rsi_pkg.sv @@
// Shared types and constants of the ray-sphere intersection block.
package rsi_pkg;

    localparam int COORD_W   = 32;
    localparam int DIR_W     = 16;
    localparam int DIR_FRAC  = 15;
    localparam int RADIUS_W  = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

    // Edges from request acceptance to the edge that takes its result.
    localparam int LATENCY = 85;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
    } t_ray_req;

    typedef struct packed {
        logic                      is_hit;
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] hit_z;
        logic signed [DIR_W-1:0]   normal_x;
        logic signed [DIR_W-1:0]   normal_y;
        logic signed [DIR_W-1:0]   normal_z;
    } t_ray_res;

endpackage

@@ rtl/ray_sphere_intersect.sv @@
// Ray-sphere intersection pipeline: one ray request per clock, one result per request.
//
// A request is taken on every clock edge with start high; busy is low except during
// reset. Each result appears on o_res for one cycle with o_res_valid high, in request
// order; the receiver cannot stall it. The delay is set by the stage chain: seven
// stages of vector setup and distance test, a 31-stage square root for the half chord,
// nine stages for the hit point and normal scaling, a 21-stage square root for the
// normal length, a 16-stage divider per normal component and one output register. The
// user must write the sphere registers only while no request is in flight; the block
// does not enforce this. The configuration port is always ready.
module ray_sphere_intersect (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  rsi_pkg::t_ray_req                 i_req,
    output logic                              o_res_valid,
    output rsi_pkg::t_ray_res                 o_res,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import rsi_pkg::*;

    localparam int SQ1_W = 31;
    localparam int SQ2_W = 21;
    localparam int DIV_W = 16;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] o;
        logic [2:0][DIR_W-1:0]   d;
    } t_geo;

    typedef struct packed {
        logic        miss;
        t_geo        geo;
        logic [33:0] tca;
    } t_ctx1;

    typedef struct packed {
        logic                    miss;
        logic [2:0][COORD_W-1:0] hit;
    } t_ctx2;

    typedef struct packed {
        logic                    miss;
        logic [2:0][COORD_W-1:0] hit;
        logic [2:0]              neg;
    } t_ctx3;

    typedef struct packed {
        logic                    miss;
        logic                    zero;
        logic [2:0][COORD_W-1:0] hit;
        logic [2:0]              neg;
        logic [2:0][19:0]        nm;
    } t_ctx4;

    // Configuration registers.
    logic signed [COORD_W-1:0] r_center [3];
    logic [RADIUS_W-1:0]       r_radius;
    logic [61:0]               r_radius_sq;

    logic accept;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_radius    <= RADIUS_RESET;
            r_radius_sq <= 62'h1_0000_0000;
        end else begin
            r_radius_sq <= r_radius * r_radius;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CENTER_X: r_center[0] <= i_cfg_data;
                    CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                    CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                    CFG_RADIUS:   r_radius    <= i_cfg_data[RADIUS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- front stages ----------------
    t_geo                      n_a1_geo;
    logic signed [32:0]        n_a1_l [3];
    logic signed [48:0]        n_a2_prod [3];
    logic signed [50:0]        n_a3_sum;
    t_ctx1                     n_a3_ctx;
    logic signed [50:0]        n_a4_pp [3];
    logic signed [36:0]        n_a5_dist [3];
    logic [36:0]               n_a5_abs [3];
    logic                      n_a6_over;
    t_ctx1                     n_a6_ctx;
    logic [61:0]               n_a6_sq [3];
    logic [63:0]               n_a7_d2;
    t_ctx1                     n_a7_ctx;

    logic                      r_a1_v, r_a2_v, r_a3_v, r_a4_v, r_a5_v, r_a6_v, r_a7_v;
    t_geo                      r_a1_geo, r_a2_geo;
    logic signed [32:0]        r_a1_l [3];
    logic signed [32:0]        r_a2_l [3];
    logic signed [32:0]        r_a3_l [3];
    logic signed [32:0]        r_a4_l [3];
    logic signed [48:0]        r_a2_prod [3];
    t_ctx1                     r_a3_ctx, r_a4_ctx, r_a5_ctx, r_a6_ctx, r_a7_ctx;
    logic signed [50:0]        r_a4_pp [3];
    logic [36:0]               r_a5_abs [3];
    logic [61:0]               r_a6_sq [3];
    logic [61:0]               r_a7_diff;

    always_comb begin
        n_a1_geo.o = {i_req.origin_z, i_req.origin_y, i_req.origin_x};
        n_a1_geo.d = {i_req.dir_z, i_req.dir_y, i_req.dir_x};
        n_a1_l[0]  = r_center[0] - i_req.origin_x;
        n_a1_l[1]  = r_center[1] - i_req.origin_y;
        n_a1_l[2]  = r_center[2] - i_req.origin_z;

        for (int i = 0; i < 3; i++) begin
            n_a2_prod[i] = $signed(r_a1_geo.d[i]) * r_a1_l[i];
        end

        n_a3_sum     = r_a2_prod[0] + r_a2_prod[1] + r_a2_prod[2];
        n_a3_ctx.geo = r_a2_geo;
        n_a3_ctx.miss = n_a3_sum[50];
        // Saturate the projection length to 34 bits.
        n_a3_ctx.tca = (n_a3_sum[50:49] != 2'b00) ? '1 : n_a3_sum[48:DIR_FRAC];

        for (int i = 0; i < 3; i++) begin
            n_a4_pp[i]   = $signed(r_a3_ctx.geo.d[i]) * $signed({1'b0, r_a3_ctx.tca});
            n_a5_dist[i] = $signed(r_a4_pp[i][50:DIR_FRAC]) - r_a4_l[i];
            n_a5_abs[i]  = n_a5_dist[i][36] ? 37'(-n_a5_dist[i]) : 37'(n_a5_dist[i]);
            n_a6_sq[i]   = r_a5_abs[i][30:0] * r_a5_abs[i][30:0];
        end

        n_a6_over = (r_a5_abs[0] > {6'b0, r_radius}) || (r_a5_abs[1] > {6'b0, r_radius})
                 || (r_a5_abs[2] > {6'b0, r_radius});
        n_a6_ctx      = r_a5_ctx;
        n_a6_ctx.miss = r_a5_ctx.miss | n_a6_over;

        n_a7_d2  = 64'(r_a6_sq[0]) + 64'(r_a6_sq[1]) + 64'(r_a6_sq[2]);
        n_a7_ctx = r_a6_ctx;
        n_a7_ctx.miss = r_a6_ctx.miss | (n_a7_d2 > 64'(r_radius_sq));
    end

    always_ff @(posedge i_clk) begin
        r_a1_geo  <= n_a1_geo;
        r_a1_l    <= n_a1_l;
        r_a2_geo  <= r_a1_geo;
        r_a2_l    <= r_a1_l;
        r_a2_prod <= n_a2_prod;
        r_a3_ctx  <= n_a3_ctx;
        r_a3_l    <= r_a2_l;
        r_a4_ctx  <= r_a3_ctx;
        r_a4_l    <= r_a3_l;
        r_a4_pp   <= n_a4_pp;
        r_a5_ctx  <= r_a4_ctx;
        r_a5_abs  <= n_a5_abs;
        r_a6_ctx  <= n_a6_ctx;
        r_a6_sq   <= n_a6_sq;
        r_a7_ctx  <= n_a7_ctx;
        r_a7_diff <= r_radius_sq - n_a7_d2[61:0];
    end

    // ---------------- half chord square root ----------------
    logic [61:0]      p_s1_val  [SQ1_W];
    logic [SQ1_W+1:0] p_s1_rem  [SQ1_W];
    logic [SQ1_W-1:0] p_s1_root [SQ1_W];
    logic [SQ1_W+1:0] n_s1_sh   [SQ1_W];
    logic [SQ1_W+1:0] n_s1_trial[SQ1_W];
    logic             n_s1_ge   [SQ1_W];

    logic             r_s1_v    [SQ1_W];
    t_ctx1            r_s1_ctx  [SQ1_W];
    logic [61:0]      r_s1_val  [SQ1_W];
    logic [SQ1_W+1:0] r_s1_rem  [SQ1_W];
    logic [SQ1_W-1:0] r_s1_root [SQ1_W];

    always_comb begin
        for (int j = 0; j < SQ1_W; j++) begin
            if (j == 0) begin
                p_s1_val[j]  = r_a7_diff;
                p_s1_rem[j]  = '0;
                p_s1_root[j] = '0;
            end else begin
                p_s1_val[j]  = r_s1_val[j-1];
                p_s1_rem[j]  = r_s1_rem[j-1];
                p_s1_root[j] = r_s1_root[j-1];
            end
            n_s1_sh[j]    = {p_s1_rem[j][SQ1_W-1:0], p_s1_val[j][2*(SQ1_W-1-j) +: 2]};
            n_s1_trial[j] = {p_s1_root[j], 2'b01};
            n_s1_ge[j]    = n_s1_sh[j] >= n_s1_trial[j];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < SQ1_W; j++) begin
            r_s1_ctx[j]  <= (j == 0) ? r_a7_ctx : r_s1_ctx[j-1];
            r_s1_val[j]  <= p_s1_val[j];
            r_s1_rem[j]  <= n_s1_ge[j] ? n_s1_sh[j] - n_s1_trial[j] : n_s1_sh[j];
            r_s1_root[j] <= {p_s1_root[j][SQ1_W-2:0], n_s1_ge[j]};
        end
    end

    // ---------------- hit point and normal setup ----------------
    logic signed [34:0]  n_b1_t;
    logic signed [50:0]  n_b2_pp [3];
    logic signed [36:0]  n_b3_sum [3];
    t_ctx2               n_b3_ctx;
    logic signed [32:0]  n_b4_n [3];
    logic [32:0]         n_b4_mag [3];
    t_ctx3               n_b4_ctx;
    logic [32:0]         n_b5_m01, n_b5_m;
    logic [32:0]         n_b6_m;
    logic [32:0]         n_b6_mag [3];
    logic [32:0]         n_b7_m;
    logic [32:0]         n_b7_mag [3];
    t_ctx4               n_b7_ctx;
    logic [39:0]         n_b8_sq [3];

    logic                r_b1_v, r_b2_v, r_b3_v, r_b4_v, r_b5_v, r_b6_v, r_b7_v, r_b8_v, r_b9_v;
    t_ctx1               r_b1_ctx, r_b2_ctx;
    logic signed [34:0]  r_b1_t;
    logic signed [50:0]  r_b2_pp [3];
    t_ctx2               r_b3_ctx;
    t_ctx3               r_b4_ctx, r_b5_ctx, r_b6_ctx;
    logic [32:0]         r_b4_mag [3];
    logic [32:0]         r_b5_mag [3];
    logic [32:0]         r_b5_m;
    logic                r_b5_zero, r_b6_zero;
    logic [32:0]         r_b6_m;
    logic [32:0]         r_b6_mag [3];
    t_ctx4               r_b7_ctx, r_b8_ctx, r_b9_ctx;
    logic [39:0]         r_b8_sq [3];
    logic [41:0]         r_b9_sum;

    always_comb begin
        n_b1_t = $signed({1'b0, r_s1_ctx[SQ1_W-1].tca})
               - $signed({4'b0, r_s1_root[SQ1_W-1]});

        n_b3_ctx.miss = r_b2_ctx.miss;
        for (int i = 0; i < 3; i++) begin
            n_b2_pp[i]  = $signed(r_b1_ctx.geo.d[i]) * r_b1_t;
            n_b3_sum[i] = $signed(r_b2_ctx.geo.o[i]) + $signed(r_b2_pp[i][50:DIR_FRAC]);
            if (n_b3_sum[i][36:31] != {6{n_b3_sum[i][31]}}) begin
                n_b3_ctx.hit[i] = n_b3_sum[i][36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                n_b3_ctx.hit[i] = n_b3_sum[i][31:0];
            end
        end

        n_b4_ctx.miss = r_b3_ctx.miss;
        n_b4_ctx.hit  = r_b3_ctx.hit;
        for (int i = 0; i < 3; i++) begin
            n_b4_n[i]       = $signed(r_b3_ctx.hit[i]) - r_center[i];
            n_b4_ctx.neg[i] = n_b4_n[i][32];
            n_b4_mag[i]     = n_b4_n[i][32] ? 33'(-n_b4_n[i]) : 33'(n_b4_n[i]);
        end

        n_b5_m01 = (r_b4_mag[0] > r_b4_mag[1]) ? r_b4_mag[0] : r_b4_mag[1];
        n_b5_m   = (n_b5_m01 > r_b4_mag[2]) ? n_b5_m01 : r_b4_mag[2];

        // A magnitude never exceeds 2^32 - 1, so the largest one is left-justified
        // to bit 31; the others follow with the same shift.
        n_b6_m   = r_b5_m;
        n_b6_mag = r_b5_mag;
        if (n_b6_m[31:16] == '0) begin
            n_b6_m = n_b6_m << 16;
            for (int i = 0; i < 3; i++) n_b6_mag[i] = n_b6_mag[i] << 16;
        end
        if (n_b6_m[31:24] == '0) begin
            n_b6_m = n_b6_m << 8;
            for (int i = 0; i < 3; i++) n_b6_mag[i] = n_b6_mag[i] << 8;
        end

        n_b7_m   = r_b6_m;
        n_b7_mag = r_b6_mag;
        if (n_b7_m[31:28] == '0) begin
            n_b7_m = n_b7_m << 4;
            for (int i = 0; i < 3; i++) n_b7_mag[i] = n_b7_mag[i] << 4;
        end
        if (n_b7_m[31:30] == '0) begin
            n_b7_m = n_b7_m << 2;
            for (int i = 0; i < 3; i++) n_b7_mag[i] = n_b7_mag[i] << 2;
        end
        if (!n_b7_m[31]) begin
            for (int i = 0; i < 3; i++) n_b7_mag[i] = n_b7_mag[i] << 1;
        end

        // Taking bits 31 down to 12 places the largest magnitude in [2^19, 2^20).
        n_b7_ctx.miss = r_b6_ctx.miss;
        n_b7_ctx.zero = r_b6_zero;
        n_b7_ctx.hit  = r_b6_ctx.hit;
        n_b7_ctx.neg  = r_b6_ctx.neg;
        for (int i = 0; i < 3; i++) begin
            n_b7_ctx.nm[i] = n_b7_mag[i][31:12];
            n_b8_sq[i]     = r_b7_ctx.nm[i] * r_b7_ctx.nm[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_ctx  <= r_s1_ctx[SQ1_W-1];
        r_b1_t    <= n_b1_t;
        r_b2_ctx  <= r_b1_ctx;
        r_b2_pp   <= n_b2_pp;
        r_b3_ctx  <= n_b3_ctx;
        r_b4_ctx  <= n_b4_ctx;
        r_b4_mag  <= n_b4_mag;
        r_b5_ctx  <= r_b4_ctx;
        r_b5_mag  <= r_b4_mag;
        r_b5_m    <= n_b5_m;
        r_b5_zero <= (n_b5_m == '0);
        r_b6_ctx  <= r_b5_ctx;
        r_b6_zero <= r_b5_zero;
        r_b6_m    <= n_b6_m;
        r_b6_mag  <= n_b6_mag;
        r_b7_ctx  <= n_b7_ctx;
        r_b8_ctx  <= r_b7_ctx;
        r_b8_sq   <= n_b8_sq;
        r_b9_ctx  <= r_b8_ctx;
        r_b9_sum  <= 42'(r_b8_sq[0]) + 42'(r_b8_sq[1]) + 42'(r_b8_sq[2]);
    end

    // ---------------- normal length square root ----------------
    logic [41:0]      p_s2_val  [SQ2_W];
    logic [SQ2_W+1:0] p_s2_rem  [SQ2_W];
    logic [SQ2_W-1:0] p_s2_root [SQ2_W];
    logic [SQ2_W+1:0] n_s2_sh   [SQ2_W];
    logic [SQ2_W+1:0] n_s2_trial[SQ2_W];
    logic             n_s2_ge   [SQ2_W];

    logic             r_s2_v    [SQ2_W];
    t_ctx4            r_s2_ctx  [SQ2_W];
    logic [41:0]      r_s2_val  [SQ2_W];
    logic [SQ2_W+1:0] r_s2_rem  [SQ2_W];
    logic [SQ2_W-1:0] r_s2_root [SQ2_W];

    always_comb begin
        for (int j = 0; j < SQ2_W; j++) begin
            if (j == 0) begin
                p_s2_val[j]  = r_b9_sum;
                p_s2_rem[j]  = '0;
                p_s2_root[j] = '0;
            end else begin
                p_s2_val[j]  = r_s2_val[j-1];
                p_s2_rem[j]  = r_s2_rem[j-1];
                p_s2_root[j] = r_s2_root[j-1];
            end
            n_s2_sh[j]    = {p_s2_rem[j][SQ2_W-1:0], p_s2_val[j][2*(SQ2_W-1-j) +: 2]};
            n_s2_trial[j] = {p_s2_root[j], 2'b01};
            n_s2_ge[j]    = n_s2_sh[j] >= n_s2_trial[j];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < SQ2_W; j++) begin
            r_s2_ctx[j]  <= (j == 0) ? r_b9_ctx : r_s2_ctx[j-1];
            r_s2_val[j]  <= p_s2_val[j];
            r_s2_rem[j]  <= n_s2_ge[j] ? n_s2_sh[j] - n_s2_trial[j] : n_s2_sh[j];
            r_s2_root[j] <= {p_s2_root[j][SQ2_W-2:0], n_s2_ge[j]};
        end
    end

    // ---------------- normal division, three lanes ----------------
    logic [20:0] p_dv_len [DIV_W];
    logic [20:0] p_dv_rem [DIV_W][3];
    logic [15:0] p_dv_q   [DIV_W][3];
    logic [21:0] n_dv_sh  [DIV_W][3];
    logic        n_dv_ge  [DIV_W][3];

    logic        r_dv_v   [DIV_W];
    t_ctx4       r_dv_ctx [DIV_W];
    logic [20:0] r_dv_len [DIV_W];
    logic [20:0] r_dv_rem [DIV_W][3];
    logic [15:0] r_dv_q   [DIV_W][3];

    always_comb begin
        for (int j = 0; j < DIV_W; j++) begin
            p_dv_len[j] = (j == 0) ? r_s2_root[SQ2_W-1] : r_dv_len[j-1];
            for (int i = 0; i < 3; i++) begin
                // The dividend is the magnitude times 2^15; only its lowest bit
                // reaches past the first quotient step.
                if (j == 0) begin
                    p_dv_rem[j][i] = {2'b00, r_s2_ctx[SQ2_W-1].nm[i][19:1]};
                    p_dv_q[j][i]   = '0;
                    n_dv_sh[j][i]  = {p_dv_rem[j][i], r_s2_ctx[SQ2_W-1].nm[i][0]};
                end else begin
                    p_dv_rem[j][i] = r_dv_rem[j-1][i];
                    p_dv_q[j][i]   = r_dv_q[j-1][i];
                    n_dv_sh[j][i]  = {p_dv_rem[j][i], 1'b0};
                end
                n_dv_ge[j][i] = n_dv_sh[j][i] >= {1'b0, p_dv_len[j]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIV_W; j++) begin
            r_dv_ctx[j] <= (j == 0) ? r_s2_ctx[SQ2_W-1] : r_dv_ctx[j-1];
            r_dv_len[j] <= p_dv_len[j];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[j][i] <= n_dv_ge[j][i]
                                ? 21'(n_dv_sh[j][i] - {1'b0, p_dv_len[j]})
                                : n_dv_sh[j][i][20:0];
                r_dv_q[j][i]   <= {p_dv_q[j][i][14:0], n_dv_ge[j][i]};
            end
        end
    end

    // ---------------- result register ----------------
    t_ctx4       out_ctx;
    logic [15:0] n_out_norm [3];
    t_ray_res    n_res;
    t_ray_res    r_res;
    logic        r_res_v;

    always_comb begin
        out_ctx = r_dv_ctx[DIV_W-1];
        for (int i = 0; i < 3; i++) begin
            if (out_ctx.miss || out_ctx.zero) begin
                n_out_norm[i] = '0;
            end else if (out_ctx.neg[i]) begin
                n_out_norm[i] = -r_dv_q[DIV_W-1][i];
            end else begin
                n_out_norm[i] = r_dv_q[DIV_W-1][i][15] ? 16'h7FFF : r_dv_q[DIV_W-1][i];
            end
        end
        n_res.is_hit   = ~out_ctx.miss;
        n_res.hit_x    = out_ctx.miss ? '0 : out_ctx.hit[0];
        n_res.hit_y    = out_ctx.miss ? '0 : out_ctx.hit[1];
        n_res.hit_z    = out_ctx.miss ? '0 : out_ctx.hit[2];
        n_res.normal_x = n_out_norm[0];
        n_res.normal_y = n_out_norm[1];
        n_res.normal_z = n_out_norm[2];
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_v <= 1'b0; r_a2_v <= 1'b0; r_a3_v <= 1'b0; r_a4_v <= 1'b0;
            r_a5_v <= 1'b0; r_a6_v <= 1'b0; r_a7_v <= 1'b0;
            r_b1_v <= 1'b0; r_b2_v <= 1'b0; r_b3_v <= 1'b0; r_b4_v <= 1'b0;
            r_b5_v <= 1'b0; r_b6_v <= 1'b0; r_b7_v <= 1'b0; r_b8_v <= 1'b0;
            r_b9_v <= 1'b0;
            for (int j = 0; j < SQ1_W; j++) r_s1_v[j] <= 1'b0;
            for (int j = 0; j < SQ2_W; j++) r_s2_v[j] <= 1'b0;
            for (int j = 0; j < DIV_W; j++) r_dv_v[j] <= 1'b0;
            r_res_v <= 1'b0;
        end else begin
            r_a1_v <= accept;
            r_a2_v <= r_a1_v; r_a3_v <= r_a2_v; r_a4_v <= r_a3_v;
            r_a5_v <= r_a4_v; r_a6_v <= r_a5_v; r_a7_v <= r_a6_v;
            for (int j = 0; j < SQ1_W; j++) r_s1_v[j] <= (j == 0) ? r_a7_v : r_s1_v[j-1];
            r_b1_v <= r_s1_v[SQ1_W-1];
            r_b2_v <= r_b1_v; r_b3_v <= r_b2_v; r_b4_v <= r_b3_v; r_b5_v <= r_b4_v;
            r_b6_v <= r_b5_v; r_b7_v <= r_b6_v; r_b8_v <= r_b7_v; r_b9_v <= r_b8_v;
            for (int j = 0; j < SQ2_W; j++) r_s2_v[j] <= (j == 0) ? r_b9_v : r_s2_v[j-1];
            for (int j = 0; j < DIV_W; j++) r_dv_v[j] <= (j == 0) ? r_s2_v[SQ2_W-1] : r_dv_v[j-1];
            r_res_v <= r_dv_v[DIV_W-1];
        end
    end

    assign o_res_valid = r_res_v;
    assign o_res       = r_res;

endmodule

@@ rtl/rsi_checker.sv @@
// Port-level checker for the ray-sphere intersection block, with its bind statement.
module rsi_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_res_valid,
    input rsi_pkg::t_ray_res o_res
);
    import rsi_pkg::*;

    // Every request returns a result after the fixed pipeline latency.
    a_request_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_res_valid)
        else $error("request did not produce a result on time");

    // No result appears without a request taken the pipeline latency earlier.
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    // A miss carries an all-zero point and normal.
    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.is_hit |->
            o_res.hit_x == '0 && o_res.hit_y == '0 && o_res.hit_z == '0 &&
            o_res.normal_x == '0 && o_res.normal_y == '0 && o_res.normal_z == '0)
        else $error("miss result with nonzero payload");

    // Reset flushes the pipeline.
    a_reset_flushes: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result strobe after reset");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
